FILE: design/mcfec_pkg.sv
// Shared types, codes and helpers for the motor command frame and encoder counter.
`default_nettype none
package mcfec_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int IDX_BITS    = $clog2(FRAME_BYTES);

    localparam logic [7:0] HEADER_MARK = 8'd125;
    localparam logic [7:0] FULL_DUTY   = 8'd100;

    // request kinds on the input tuser
    localparam logic [1:0] FUNC_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_EDGE   = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // report kinds on the output tuser
    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_ENC  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // frame mode and direction bytes
    localparam logic [7:0] MODE_STOP = 8'd0;
    localparam logic [7:0] MODE_RUN  = 8'd1;
    localparam logic [7:0] DIR_OFF   = 8'd0;
    localparam logic [7:0] DIR_FWD   = 8'd1;
    localparam logic [7:0] DIR_REV   = 8'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] rx_byte;
        logic       encoder_select;
        logic       edge_channel;
        logic       level_a;
        logic       level_b;
    } item_t;

    typedef struct packed {
        logic       done;
        logic [7:0] header;
        logic [7:0] dir_one;
        logic [7:0] spd_one;
        logic [7:0] dir_two;
        logic [7:0] spd_two;
        logic [7:0] mode;
    } frame_t;

    typedef struct packed {
        logic [1:0]         report_kind;
        logic               ack_value;
        logic signed [31:0] count_one;
        logic signed [31:0] count_two;
        logic [31:0]        elapsed_ticks;
        logic               one_fwd_pin;
        logic               one_rev_pin;
        logic [6:0]         one_duty;
        logic               two_fwd_pin;
        logic               two_rev_pin;
        logic [6:0]         two_duty;
    } result_t;

    // pin pair {rev, fwd}; an unknown direction keeps the current levels
    function automatic logic [1:0] dir_pins(input logic [7:0] dir, input logic [1:0] cur);
        logic [1:0] pins;
        case (dir)
            DIR_OFF: pins = 2'b00;
            DIR_FWD: pins = 2'b01;
            DIR_REV: pins = 2'b10;
            default: pins = cur;
        endcase
        return pins;
    endfunction

    // inverted duty in percent, floored at zero
    function automatic logic [6:0] inv_duty(input logic [7:0] speed);
        logic [7:0] diff;
        diff = (speed >= FULL_DUTY) ? 8'd0 : (FULL_DUTY - speed);
        return diff[6:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/motor_command_frame_and_encoder_counter.sv
// Top level: input register, frame assembler, motor/encoder state and result register.
`default_nettype none
// Takes one request per clock: a received byte, an encoder edge or a time tick,
// selected by s_tuser. Every sixth byte closes a frame; a frame whose header is
// 125 and mode 1 sets the motor pins and inverted duties and starts the tick
// counter, mode 0 stops both motors and clears counts and ticks; either answers
// with an acknowledge. Each encoder edge steps a x4 quadrature count and reports;
// each tick while running advances the tick total and reports. Other requests
// give no report. A request passes through an input register and is decided from
// there straight into the output register once that register can take its report;
// one request per cycle is sustained while m_tready stays high. COUNT_BITS sets
// the width of the stored encoder counts; reports carry their low 32 bits.
module motor_command_frame_and_encoder_counter
    import mcfec_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,  // rx_byte[7:0], encoder_select, edge_channel,
                                        // level_a, level_b, zero pad
    input  wire logic [1:0]   s_tuser,  // func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [119:0]      m_tdata,  // ack_value, count_one[31:0], count_two[31:0],
                                        // elapsed_ticks[31:0], one_fwd_pin, one_rev_pin,
                                        // one_duty[6:0], two_fwd_pin, two_rev_pin,
                                        // two_duty[6:0], zero pad
    output logic [1:0]        m_tuser   // report_kind
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    logic    fire;
    logic    has_result;
    result_t result;
    frame_t  frame;

    // decide the held request once the result register can take its report
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= has_result;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func           <= s_tuser;
            in_item_reg.rx_byte        <= s_tdata[7:0];
            in_item_reg.encoder_select <= s_tdata[8];
            in_item_reg.edge_channel   <= s_tdata[9];
            in_item_reg.level_a        <= s_tdata[10];
            in_item_reg.level_b        <= s_tdata[11];
        end
        if (fire && has_result)
        begin
            out_result_reg <= result;
        end
    end

    mcfec_frame_asm u_frame_asm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_fire (fire && (in_item_reg.func == FUNC_BYTE)),
        .rx_byte   (in_item_reg.rx_byte),
        .frame     (frame)
    );

    mcfec_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .item       (in_item_reg),
        .frame      (frame),
        .has_result (has_result),
        .result     (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.report_kind;
    assign m_tdata  = {5'd0,
                       out_result_reg.two_duty,
                       out_result_reg.two_rev_pin,
                       out_result_reg.two_fwd_pin,
                       out_result_reg.one_duty,
                       out_result_reg.one_rev_pin,
                       out_result_reg.one_fwd_pin,
                       out_result_reg.elapsed_ticks,
                       out_result_reg.count_two,
                       out_result_reg.count_one,
                       out_result_reg.ack_value};

endmodule
`default_nettype wire

FILE: design/mcfec_frame_asm.sv
// Frame assembler: collects received bytes and presents a complete frame.
`default_nettype none
module mcfec_frame_asm
    import mcfec_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_fire,
    input  wire logic [7:0] rx_byte,
    output frame_t          frame
);

    logic [IDX_BITS-1:0] byte_index_reg;
    logic [IDX_BITS-1:0] byte_index_next;
    logic [7:0]          frame_store_reg [FRAME_BYTES-1];
    logic                last_byte;

    assign last_byte = (byte_index_reg == IDX_BITS'(FRAME_BYTES - 1));

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (byte_fire)
        begin
            byte_index_next = last_byte ? '0 : byte_index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            for (int i = 0; i < FRAME_BYTES - 1; i++)
            begin
                frame_store_reg[i] <= '0;
            end
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            if (byte_fire && !last_byte)
            begin
                frame_store_reg[byte_index_reg] <= rx_byte;
            end
        end
    end

    // the mode byte is the one arriving now
    always_comb
    begin
        frame.done    = byte_fire && last_byte;
        frame.header  = frame_store_reg[0];
        frame.dir_one = frame_store_reg[1];
        frame.spd_one = frame_store_reg[2];
        frame.dir_two = frame_store_reg[3];
        frame.spd_two = frame_store_reg[4];
        frame.mode    = rx_byte;
    end

endmodule
`default_nettype wire

FILE: design/mcfec_ctrl.sv
// Motor and encoder state: pins, duties, run flag, counts and tick total.
`default_nettype none
module mcfec_ctrl
    import mcfec_pkg::*;
#(
    parameter int COUNT_BITS = 32
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   fire,
    input  wire item_t  item,
    input  wire frame_t frame,
    output logic        has_result,
    output result_t     result
);

    logic                  running_reg, running_next;
    logic [COUNT_BITS-1:0] pos_one_reg, pos_one_next;
    logic [COUNT_BITS-1:0] pos_two_reg, pos_two_next;
    logic [31:0]           ticks_reg, ticks_next;
    logic [3:0]            pins_reg, pins_next;
    logic [6:0]            duty_one_reg, duty_one_next;
    logic [6:0]            duty_two_reg, duty_two_next;
    logic                  count_up;
    logic [COUNT_BITS-1:0] pos_sel, pos_step;
    logic                  ack_value;
    logic [1:0]            kind;

    assign count_up = item.edge_channel ? (item.level_a == item.level_b)
                                        : (item.level_a != item.level_b);
    assign pos_sel  = item.encoder_select ? pos_two_reg : pos_one_reg;
    assign pos_step = count_up ? pos_sel + 1'b1 : pos_sel - 1'b1;

    always_comb
    begin
        running_next  = running_reg;
        pos_one_next  = pos_one_reg;
        pos_two_next  = pos_two_reg;
        ticks_next    = ticks_reg;
        pins_next     = pins_reg;
        duty_one_next = duty_one_reg;
        duty_two_next = duty_two_reg;
        has_result    = 1'b0;
        ack_value     = 1'b0;
        kind          = KIND_ACK;
        case (item.func)
            FUNC_BYTE:
            begin
                if (frame.done && frame.header == HEADER_MARK)
                begin
                    if (frame.mode == MODE_RUN)
                    begin
                        pins_next[1:0] = dir_pins(frame.dir_one, pins_reg[1:0]);
                        pins_next[3:2] = dir_pins(frame.dir_two, pins_reg[3:2]);
                        duty_one_next  = inv_duty(frame.spd_one);
                        duty_two_next  = inv_duty(frame.spd_two);
                        running_next   = 1'b1;
                        has_result     = 1'b1;
                        ack_value      = 1'b1;
                    end
                    else if (frame.mode == MODE_STOP)
                    begin
                        pins_next     = '0;
                        duty_one_next = FULL_DUTY[6:0];
                        duty_two_next = FULL_DUTY[6:0];
                        running_next  = 1'b0;
                        ticks_next    = '0;
                        pos_one_next  = '0;
                        pos_two_next  = '0;
                        has_result    = 1'b1;
                    end
                end
            end
            FUNC_EDGE:
            begin
                if (item.encoder_select)
                begin
                    pos_two_next = pos_step;
                end
                else
                begin
                    pos_one_next = pos_step;
                end
                has_result = 1'b1;
                kind       = KIND_ENC;
            end
            FUNC_TICK:
            begin
                if (running_reg)
                begin
                    ticks_next = ticks_reg + 1'b1;
                    has_result = 1'b1;
                    kind       = KIND_TICK;
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // report the state as it stands after this request
    always_comb
    begin
        result.report_kind   = kind;
        result.ack_value     = ack_value;
        result.count_one     = 32'(pos_one_next);
        result.count_two     = 32'(pos_two_next);
        result.elapsed_ticks = ticks_next;
        result.one_fwd_pin   = pins_next[0];
        result.one_rev_pin   = pins_next[1];
        result.one_duty      = duty_one_next;
        result.two_fwd_pin   = pins_next[2];
        result.two_rev_pin   = pins_next[3];
        result.two_duty      = duty_two_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            pos_one_reg  <= '0;
            pos_two_reg  <= '0;
            ticks_reg    <= '0;
            pins_reg     <= '0;
            duty_one_reg <= '0;
            duty_two_reg <= '0;
        end
        else if (fire)
        begin
            running_reg  <= running_next;
            pos_one_reg  <= pos_one_next;
            pos_two_reg  <= pos_two_next;
            ticks_reg    <= ticks_next;
            pins_reg     <= pins_next;
            duty_one_reg <= duty_one_next;
            duty_two_reg <= duty_two_next;
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/motor_command_frame_and_encoder_counter_tb.sv
// Self-checking testbench for the motor command frame decoder and encoder counter.
module motor_command_frame_and_encoder_counter_tb;
    import mcfec_pkg::*;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata = '0;  // rx_byte[7:0], encoder_select, edge_channel,
                                 // level_a, level_b, zero pad
    logic [1:0]   s_tuser = '0;  // func
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;       // ack_value, count_one[31:0], count_two[31:0],
                                 // elapsed_ticks[31:0], one_fwd_pin, one_rev_pin,
                                 // one_duty[6:0], two_fwd_pin, two_rev_pin,
                                 // two_duty[6:0], zero pad
    logic [1:0]   m_tuser;       // report_kind

    motor_command_frame_and_encoder_counter dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    item_t       request_queue[$];
    result_t     expected_reports[$];
    int unsigned mismatch_count = 0;
    int unsigned sent_count = 0;
    int unsigned ack_seen = 0;
    int unsigned enc_seen = 0;
    int unsigned tick_seen = 0;
    int unsigned frame_offset = 0;

    // predictor state
    logic [7:0]  frame_bytes [FRAME_BYTES];
    int unsigned byte_count = 0;
    logic        motors_running = 1'b0;
    logic [31:0] pos_one = '0;
    logic [31:0] pos_two = '0;
    logic [31:0] tick_total = '0;
    logic [3:0]  pins = '0;  // one fwd, one rev, two fwd, two rev
    logic [6:0]  duty_one = '0;
    logic [6:0]  duty_two = '0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    function automatic result_t motor_snapshot(input logic [1:0] kind, input logic ack);
        result_t r;
        r.report_kind   = kind;
        r.ack_value     = ack;
        r.count_one     = pos_one;
        r.count_two     = pos_two;
        r.elapsed_ticks = tick_total;
        r.one_fwd_pin   = pins[0];
        r.one_rev_pin   = pins[1];
        r.one_duty      = duty_one;
        r.two_fwd_pin   = pins[2];
        r.two_rev_pin   = pins[3];
        r.two_duty      = duty_two;
        return r;
    endfunction

    task automatic apply_motor(input logic which, input logic [7:0] dir,
                               input logic [7:0] speed);
        logic [1:0] pair;
        logic [6:0] duty;
        pair = which ? pins[3:2] : pins[1:0];
        // unknown direction keeps the pair
        if (dir == DIR_OFF)
            pair = 2'b00;
        else if (dir == DIR_FWD)
            pair = 2'b01;
        else if (dir == DIR_REV)
            pair = 2'b10;
        duty = (speed >= FULL_DUTY) ? 7'd0 : 7'(FULL_DUTY - speed);
        if (which)
        begin
            pins[3:2] = pair;
            duty_two  = duty;
        end
        else
        begin
            pins[1:0] = pair;
            duty_one  = duty;
        end
    endtask

    task automatic predict_report(input item_t it);
        logic up;
        case (it.func)
            FUNC_BYTE:
            begin
                frame_bytes[byte_count] = it.rx_byte;
                byte_count++;
                if (byte_count == FRAME_BYTES)
                begin
                    byte_count = 0;
                    if (frame_bytes[0] == HEADER_MARK)
                    begin
                        if (frame_bytes[5] == MODE_RUN)
                        begin
                            apply_motor(1'b0, frame_bytes[1], frame_bytes[2]);
                            apply_motor(1'b1, frame_bytes[3], frame_bytes[4]);
                            motors_running = 1'b1;
                            expected_reports.push_back(motor_snapshot(KIND_ACK, 1'b1));
                        end
                        else if (frame_bytes[5] == MODE_STOP)
                        begin
                            apply_motor(1'b0, DIR_OFF, 8'd0);
                            apply_motor(1'b1, DIR_OFF, 8'd0);
                            motors_running = 1'b0;
                            tick_total = '0;
                            pos_one = '0;
                            pos_two = '0;
                            expected_reports.push_back(motor_snapshot(KIND_ACK, 1'b0));
                        end
                    end
                end
            end
            FUNC_EDGE:
            begin
                up = it.edge_channel ? (it.level_a == it.level_b) : (it.level_a != it.level_b);
                if (it.encoder_select)
                    pos_two = up ? pos_two + 32'd1 : pos_two - 32'd1;
                else
                    pos_one = up ? pos_one + 32'd1 : pos_one - 32'd1;
                expected_reports.push_back(motor_snapshot(KIND_ENC, 1'b0));
            end
            FUNC_TICK:
            begin
                if (motors_running)
                begin
                    tick_total++;
                    expected_reports.push_back(motor_snapshot(KIND_TICK, 1'b0));
                end
            end
            default: ;
        endcase
    endtask

    // extra: {level_b, level_a, edge_channel, encoder_select}
    task automatic push_request(input logic [1:0] func, input logic [7:0] data,
                                input logic [3:0] extra);
        item_t it;
        it.func           = func;
        it.rx_byte        = data;
        it.encoder_select = extra[0];
        it.edge_channel   = extra[1];
        it.level_a        = extra[2];
        it.level_b        = extra[3];
        request_queue.push_back(it);
        if (func == FUNC_BYTE)
            frame_offset = (frame_offset + 1) % FRAME_BYTES;
    endtask

    task automatic push_frame(input logic [7:0] header, input logic [7:0] dir1,
                              input logic [7:0] spd1, input logic [7:0] dir2,
                              input logic [7:0] spd2, input logic [7:0] mode,
                              input logic mix);
        logic [7:0] bytes [FRAME_BYTES];
        bytes = '{header, dir1, spd1, dir2, spd2, mode};
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            push_request(FUNC_BYTE, bytes[i], 4'($urandom));
            // slip edges and ticks between frame bytes
            if (mix && $urandom_range(0, 3) == 0)
                push_request($urandom_range(0, 1) ? FUNC_EDGE : FUNC_TICK,
                             8'($urandom), 4'($urandom));
        end
    endtask

    function automatic logic [7:0] pick_dir();
        case ($urandom_range(0, 7))
            0, 1:    return DIR_OFF;
            2, 3:    return DIR_FWD;
            4, 5:    return DIR_REV;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_speed();
        return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 100)) : 8'($urandom);
    endfunction

    // driver: bursts of requests with random gaps
    item_t       current_item = '0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_report(current_item);
                sent_count++;
            end
            // hold a request that was not taken
            if (!(s_tvalid && !s_tready))
            begin
                next_valid = 1'b0;
                if (gap_left != 0)
                    gap_left--;
                else if (request_queue.size() != 0)
                begin
                    current_item = request_queue.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                                : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= next_valid;
                s_tdata  <= {4'b0000, current_item.level_b, current_item.level_a,
                             current_item.edge_channel, current_item.encoder_select,
                             current_item.rx_byte};
                s_tuser  <= current_item.func;
            end
        end
    end

    // monitor: check reports and stall on a changing ready pattern
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_reports.size() == 0)
                    report_mismatch($sformatf("report kind %0d with none expected", m_tuser));
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("report_kind", 32'(m_tuser), 32'(want.report_kind));
                    check_field("ack_value", 32'(m_tdata[0]), 32'(want.ack_value));
                    check_field("count_one", m_tdata[32:1], want.count_one);
                    check_field("count_two", m_tdata[64:33], want.count_two);
                    check_field("elapsed_ticks", m_tdata[96:65], want.elapsed_ticks);
                    check_field("one_fwd_pin", 32'(m_tdata[97]), 32'(want.one_fwd_pin));
                    check_field("one_rev_pin", 32'(m_tdata[98]), 32'(want.one_rev_pin));
                    check_field("one_duty", 32'(m_tdata[105:99]), 32'(want.one_duty));
                    check_field("two_fwd_pin", 32'(m_tdata[106]), 32'(want.two_fwd_pin));
                    check_field("two_rev_pin", 32'(m_tdata[107]), 32'(want.two_rev_pin));
                    check_field("two_duty", 32'(m_tdata[114:108]), 32'(want.two_duty));
                end
                case (m_tuser)
                    KIND_ACK: ack_seen++;
                    KIND_ENC: enc_seen++;
                    default:  tick_seen++;
                endcase
            end
            pattern_age++;
            if (pattern_age % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = 16'hFFFF;
                    1:       ready_pattern = 16'($urandom | $urandom);
                    2:       ready_pattern = 16'($urandom & $urandom);
                    default: ready_pattern = 16'($urandom);
                endcase
            end
            m_tready <= ready_pattern[pattern_age % 16];
        end
    end

    initial
    begin
        // tick while stopped and the unused request kind give nothing
        push_request(FUNC_TICK, 8'h00, 4'h0);
        push_request(FUNC_UNUSED, 8'hFF, 4'hF);
        push_frame(HEADER_MARK, DIR_FWD, 8'd0, DIR_REV, 8'd100, MODE_RUN, 1'b0);
        push_request(FUNC_TICK, 8'hFF, 4'hF);
        push_request(FUNC_EDGE, 8'h00, 4'b0100);
        push_request(FUNC_EDGE, 8'hFF, 4'b1011);
        // unknown directions keep pins, speeds above full scale saturate
        push_frame(HEADER_MARK, 8'hFF, 8'd101, 8'd3, 8'hFF, MODE_RUN, 1'b0);
        push_frame(8'd124, DIR_OFF, 8'd50, DIR_OFF, 8'd50, MODE_STOP, 1'b0);
        push_frame(HEADER_MARK, DIR_OFF, 8'd0, DIR_OFF, 8'd0, MODE_STOP, 1'b0);

        while (request_queue.size() < 1530)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                begin
                    // realign on a frame boundary with filler bytes
                    while (frame_offset != 0)
                        push_request(FUNC_BYTE, 8'($urandom), 4'($urandom));
                    push_frame(($urandom_range(0, 9) != 0) ? HEADER_MARK : 8'($urandom),
                               pick_dir(), pick_speed(), pick_dir(), pick_speed(),
                               ($urandom_range(0, 9) < 6) ? MODE_RUN :
                               ($urandom_range(0, 3) != 0) ? MODE_STOP : 8'($urandom),
                               1'($urandom));
                end
                9, 10, 11, 12, 13:
                    push_request(FUNC_EDGE, 8'($urandom), 4'($urandom));
                14, 15, 16, 17:
                    push_request(FUNC_TICK, 8'($urandom), 4'($urandom));
                18:
                    push_request(FUNC_BYTE, 8'($urandom), 4'($urandom));
                default:
                    push_request(FUNC_UNUSED, 8'($urandom), 4'($urandom));
            endcase
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("sent %0d requests; checked %0d acks, %0d encoder and %0d tick reports",
                 sent_count, ack_seen, enc_seen, tick_seen);
        if (mismatch_count == 0)
            $display("motor_command_frame_and_encoder_counter_tb: clean");
        else
            $display("motor_command_frame_and_encoder_counter_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d reports outstanding", expected_reports.size());
        $display("motor_command_frame_and_encoder_counter_tb: errors");
        $finish;
    end

endmodule

FILE: motor_command_frame_and_encoder_counter.f
design/mcfec_pkg.sv
design/mcfec_frame_asm.sv
design/mcfec_ctrl.sv
design/motor_command_frame_and_encoder_counter.sv
tb/sv/motor_command_frame_and_encoder_counter_tb.sv
